// File: rtl/sst_pkg.sv
`default_nettype none

package sst_pkg;

    // Tone buffer geometry and level.
    localparam int FRAMES       = 800;
    localparam int TONE_PERIODS = 22;
    localparam int AMPLITUDE    = 12000;

    // Field widths.
    localparam int IDX_W = 10;
    localparam int MAG_W = 15;
    localparam int OUT_W = 15;
    localparam int VOL_W = 16;
    localparam int CFG_W = 16;

    // Q1.15 volume.
    localparam int FRAC_W     = 15;
    localparam int VOL_UNITY  = 32768;
    localparam int VOL_RESET  = 3277;
    localparam int VPROD_W    = MAG_W + VOL_W;

    // Register indexes of the configuration port.
    typedef logic [1:0] t_cfg_index;
    localparam t_cfg_index CFG_LEFT_VOLUME  = 2'd0;
    localparam t_cfg_index CFG_RIGHT_VOLUME = 2'd1;
    localparam t_cfg_index CFG_MUTED        = 2'd2;

    typedef struct packed {
        logic [VOL_W-1:0] left_vol;
        logic [VOL_W-1:0] right_vol;
        logic             muted;
    } t_cfg;

    typedef struct packed {
        logic             valid;
        logic             neg;
        logic [MAG_W-1:0] mag;
    } t_tone;

    // Subtractive Euclid; both arguments are positive.
    function automatic int gcd(input int a, input int b);
        int x;
        int y;
        x = a;
        y = b;
        while (x != y) begin
            if (x > y) begin
                x = x - y;
            end else begin
                y = y - x;
            end
        end
        return x;
    endfunction

    // Every reachable quarter-wave angle is a multiple of STEP_G frames, so the
    // phase is counted in those steps: QUAD_LEN steps per quarter wave.
    localparam int STEP_G    = gcd(4 * TONE_PERIODS, FRAMES);
    localparam int PHASE_MUL = (4 * TONE_PERIODS) / STEP_G;
    localparam int QUAD_LEN  = FRAMES / STEP_G;
    localparam int PHASE_MOD = 4 * QUAD_LEN;

    localparam int PROD_MAX = PHASE_MUL * ((1 << IDX_W) - 1);
    localparam int PROD_W   = $clog2(PROD_MAX + 1);
    localparam int REM_W    = $clog2(2 * PHASE_MOD);
    localparam int PH_W     = $clog2(PHASE_MOD);
    localparam int M_W      = $clog2(QUAD_LEN + 1);

    // Reduction modulo PHASE_MOD by a reciprocal; the estimate is at most one low.
    localparam int     RECIP_SHIFT = PROD_W + $clog2(PHASE_MOD + 1);
    localparam longint RECIP       = (longint'(1) << RECIP_SHIFT) / PHASE_MOD;
    localparam longint RECIP_K     = longint'(PHASE_MUL) * RECIP;
    localparam int     EST_W       = IDX_W + $clog2(RECIP_K + 1);
    localparam int     QUOT_W      = EST_W - RECIP_SHIFT;

    localparam logic [63:0] HALF_PI_Q62  = 64'h6487ED5110B4611A;
    localparam logic [63:0] HALF_PI_STEP = HALF_PI_Q62 / 64'(FRAMES);
    localparam logic [63:0] HALF_PI_REM  = HALF_PI_Q62 % 64'(FRAMES);

    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // Quotient by long division; only used while the lookup table is built.
    function automatic logic [63:0] div_u64(input logic [63:0] a, input logic [63:0] d);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[63:0], a[i]};
            if (r >= {1'b0, d}) begin
                r    = r - {1'b0, d};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // Magnitude of the base sample for a quarter-wave angle of m frames.
    function automatic logic [MAG_W-1:0] sine_mag(input int m);
        logic [63:0]  mm;
        logic [63:0]  fr;
        logic [63:0]  x;
        logic [63:0]  x2;
        logic [63:0]  term;
        logic [63:0]  sum;
        logic [63:0]  mag;
        logic [127:0] p;
        logic         done;
        mm   = 64'(m);
        fr   = 64'(FRAMES);
        done = 1'b0;
        if (m == 0) begin
            return '0;
        end
        if (m == FRAMES) begin
            return MAG_W'(AMPLITUDE);
        end
        x    = HALF_PI_STEP * mm + div_u64(HALF_PI_REM * mm, fr);
        x2   = mul_q62(x, x);
        term = x;
        sum  = x;
        for (int k = 1; k < 40; k++) begin
            if (!done) begin
                term = div_u64(mul_q62(term, x2), 64'((2 * k) * (2 * k + 1)));
                if (term == 64'd0) begin
                    done = 1'b1;
                end else if (k % 2 == 1) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
        end
        p   = {64'd0, sum} * 128'(AMPLITUDE);
        mag = p[125:62];
        if (mag > 64'(AMPLITUDE)) begin
            mag = 64'(AMPLITUDE);
        end
        return mag[MAG_W-1:0];
    endfunction

    typedef logic [QUAD_LEN:0][MAG_W-1:0] t_mag_rom;

    function automatic t_mag_rom build_rom();
        t_mag_rom rom;
        for (int i = 0; i <= QUAD_LEN; i++) begin
            rom[i] = sine_mag(i * STEP_G);
        end
        return rom;
    endfunction

    localparam t_mag_rom MAG_ROM = build_rom();

endpackage

`default_nettype wire

// File: rtl/sst_cfg.sv
`default_nettype none

module sst_cfg (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire sst_pkg::t_cfg_index       i_cfg_index,
    input  wire logic [sst_pkg::CFG_W-1:0] i_cfg_data,
    output sst_pkg::t_cfg                  o_cfg
);

    logic [sst_pkg::VOL_W-1:0] r_left_vol;
    logic [sst_pkg::VOL_W-1:0] r_right_vol;
    logic                      r_muted;
    logic [sst_pkg::VOL_W-1:0] n_vol;

    // Gains above unity are clamped to unity.
    always_comb begin
        if (i_cfg_data > sst_pkg::CFG_W'(sst_pkg::VOL_UNITY)) begin
            n_vol = sst_pkg::VOL_W'(sst_pkg::VOL_UNITY);
        end else begin
            n_vol = sst_pkg::VOL_W'(i_cfg_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_vol  <= sst_pkg::VOL_W'(sst_pkg::VOL_RESET);
            r_right_vol <= sst_pkg::VOL_W'(sst_pkg::VOL_RESET);
            r_muted     <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                sst_pkg::CFG_LEFT_VOLUME:  r_left_vol  <= n_vol;
                sst_pkg::CFG_RIGHT_VOLUME: r_right_vol <= n_vol;
                sst_pkg::CFG_MUTED:        r_muted     <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg.left_vol  = r_left_vol;
    assign o_cfg.right_vol = r_right_vol;
    assign o_cfg.muted     = r_muted;

    a_vol_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_left_vol <= sst_pkg::VOL_W'(sst_pkg::VOL_UNITY))
        && (r_right_vol <= sst_pkg::VOL_W'(sst_pkg::VOL_UNITY)))
        else $error("volume register above unity");

endmodule

`default_nettype wire

// File: rtl/sst_base.sv
`default_nettype none

module sst_base (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic [sst_pkg::IDX_W-1:0] i_frame_index,
    input  wire logic                      i_next_en,
    output sst_pkg::t_tone                 o_tone
);

    logic                       r_v0;
    logic [sst_pkg::IDX_W-1:0]  r_idx;
    logic                       r_v1;
    logic [sst_pkg::PROD_W-1:0] r_prod;
    logic [sst_pkg::QUOT_W-1:0] r_quot;
    logic                       r_v2;
    logic                       r_neg;
    logic [sst_pkg::MAG_W-1:0]  r_mag;

    logic                       en0;
    logic                       en1;
    logic                       en2;
    logic [sst_pkg::EST_W-1:0]  est;
    logic [sst_pkg::PROD_W-1:0] n_prod;
    logic [sst_pkg::REM_W-1:0]  rem_raw;
    logic [sst_pkg::PH_W-1:0]   phase;
    logic [1:0]                 quad;
    logic [sst_pkg::M_W-1:0]    quad_pos;
    logic [sst_pkg::M_W-1:0]    m_idx;

    // Each stage loads when it is empty or its word moves on.
    assign en2     = !r_v2 || i_next_en;
    assign en1     = !r_v1 || en2;
    assign en0     = !r_v0 || en1;
    assign o_ready = en0;

    // Stage 1: phase product and reciprocal quotient estimate.
    assign n_prod = sst_pkg::PROD_W'(r_idx) * sst_pkg::PROD_W'(sst_pkg::PHASE_MUL);
    assign est    = sst_pkg::EST_W'(r_idx) * sst_pkg::EST_W'(sst_pkg::RECIP_K);

    // Stage 2: exact remainder, quadrant split and quarter-wave lookup.
    always_comb begin
        logic [sst_pkg::PH_W-1:0] base;
        rem_raw = sst_pkg::REM_W'(r_prod
            - sst_pkg::PROD_W'(r_quot) * sst_pkg::PROD_W'(sst_pkg::PHASE_MOD));
        if (rem_raw >= sst_pkg::REM_W'(sst_pkg::PHASE_MOD)) begin
            phase = sst_pkg::PH_W'(rem_raw - sst_pkg::REM_W'(sst_pkg::PHASE_MOD));
        end else begin
            phase = sst_pkg::PH_W'(rem_raw);
        end
        priority if (phase >= sst_pkg::PH_W'(3 * sst_pkg::QUAD_LEN)) begin
            quad = 2'd3;
            base = sst_pkg::PH_W'(3 * sst_pkg::QUAD_LEN);
        end else if (phase >= sst_pkg::PH_W'(2 * sst_pkg::QUAD_LEN)) begin
            quad = 2'd2;
            base = sst_pkg::PH_W'(2 * sst_pkg::QUAD_LEN);
        end else if (phase >= sst_pkg::PH_W'(sst_pkg::QUAD_LEN)) begin
            quad = 2'd1;
            base = sst_pkg::PH_W'(sst_pkg::QUAD_LEN);
        end else begin
            quad = 2'd0;
            base = '0;
        end
        quad_pos = sst_pkg::M_W'(phase - base);
        // Odd quadrants run the quarter wave backward.
        if (quad[0]) begin
            m_idx = sst_pkg::M_W'(sst_pkg::QUAD_LEN) - quad_pos;
        end else begin
            m_idx = quad_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (en0) begin
                r_v0 <= i_valid;
            end
            if (en1) begin
                r_v1 <= r_v0;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en0 && i_valid) begin
            r_idx <= i_frame_index;
        end
        if (en1 && r_v0) begin
            r_prod <= n_prod;
            r_quot <= est[sst_pkg::EST_W-1:sst_pkg::RECIP_SHIFT];
        end
        if (en2 && r_v1) begin
            r_neg <= quad[1];
            r_mag <= sst_pkg::MAG_ROM[m_idx];
        end
    end

    assign o_tone.valid = r_v2;
    assign o_tone.neg   = r_neg;
    assign o_tone.mag   = r_mag;

    a_rem_corrected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 |-> (rem_raw < sst_pkg::REM_W'(2 * sst_pkg::PHASE_MOD)))
        else $error("phase remainder estimate off by more than one");

    a_mag_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> (r_mag <= sst_pkg::MAG_W'(sst_pkg::AMPLITUDE)))
        else $error("base magnitude above amplitude");

endmodule

`default_nettype wire

// File: rtl/sst_gain.sv
`default_nettype none

module sst_gain (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire sst_pkg::t_tone           i_tone,
    input  wire sst_pkg::t_cfg            i_cfg,
    output logic                          o_load_en,
    output logic                          o_valid,
    input  wire logic                     i_ready,
    output logic signed [sst_pkg::OUT_W-1:0] o_left_pcm,
    output logic signed [sst_pkg::OUT_W-1:0] o_right_pcm
);

    logic                                r_valid;
    logic signed [sst_pkg::OUT_W-1:0]    r_left;
    logic signed [sst_pkg::OUT_W-1:0]    r_right;
    logic        [sst_pkg::VPROD_W-1:0]  left_prod;
    logic        [sst_pkg::VPROD_W-1:0]  right_prod;
    logic        [sst_pkg::OUT_W-1:0]    left_mag;
    logic        [sst_pkg::OUT_W-1:0]    right_mag;
    logic        [sst_pkg::OUT_W-1:0]    n_left;
    logic        [sst_pkg::OUT_W-1:0]    n_right;

    assign o_load_en = !r_valid || i_ready;

    assign left_prod  = sst_pkg::VPROD_W'(i_tone.mag) * sst_pkg::VPROD_W'(i_cfg.left_vol);
    assign right_prod = sst_pkg::VPROD_W'(i_tone.mag) * sst_pkg::VPROD_W'(i_cfg.right_vol);
    assign left_mag   = left_prod[sst_pkg::FRAC_W +: sst_pkg::OUT_W];
    assign right_mag  = right_prod[sst_pkg::FRAC_W +: sst_pkg::OUT_W];

    // Scaling the magnitude before the sign is applied truncates toward zero.
    always_comb begin
        if (i_cfg.muted) begin
            n_left  = '0;
            n_right = '0;
        end else if (i_tone.neg) begin
            n_left  = '0 - left_mag;
            n_right = '0 - right_mag;
        end else begin
            n_left  = left_mag;
            n_right = right_mag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_load_en) begin
            r_valid <= i_tone.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_load_en && i_tone.valid) begin
            r_left  <= signed'(n_left);
            r_right <= signed'(n_right);
        end
    end

    assign o_valid     = r_valid;
    assign o_left_pcm  = r_left;
    assign o_right_pcm = r_right;

    a_mute_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_load_en && i_tone.valid && i_cfg.muted)
        |=> (r_left == '0 && r_right == '0))
        else $error("muted word with nonzero sample");

endmodule

`default_nettype wire

// File: rtl/stereo_sine_tone_sample_unit.sv
// A word accepted on the input reaches o_valid after passing each register below in order.
// One word per cycle is sustained while i_ready is high, through a four-register pipeline
// with no feedback: input, phase product, quarter-wave lookup, volume multiply.
// A stall at the output fills empty pipeline stages before o_ready drops.
// Reset clears all valid flags, sets both volumes to 3277 and clears mute.
`default_nettype none

module stereo_sine_tone_sample_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [sst_pkg::IDX_W-1:0]     i_frame_index,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic signed [sst_pkg::OUT_W-1:0]   o_left_pcm,
    output logic signed [sst_pkg::OUT_W-1:0]   o_right_pcm,
    input  wire logic                          i_cfg_we,
    input  wire sst_pkg::t_cfg_index           i_cfg_index,
    input  wire logic [sst_pkg::CFG_W-1:0]     i_cfg_data
);

    sst_pkg::t_cfg  cfg;
    sst_pkg::t_tone tone;
    logic           load_en;

    sst_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    sst_base u_base (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_frame_index (i_frame_index),
        .i_next_en     (load_en),
        .o_tone        (tone)
    );

    sst_gain u_gain (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tone      (tone),
        .i_cfg       (cfg),
        .o_load_en   (load_en),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_left_pcm  (o_left_pcm),
        .o_right_pcm (o_right_pcm)
    );

endmodule

`default_nettype wire
